[hdl/icmpcg_pkg.sv]
// Shared types, constants and checksum arithmetic for the ICMPv6 checksum generator.
// Used by the front, queue, back and top-level modules; depends on nothing else.
package icmpcg_pkg;

    localparam int DEFAULT_MAX_PAYLOAD = 2048;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int S_TDATA_W = 144;
    localparam int M_TDATA_W = 16;

    typedef enum logic [1:0] {
        CMD_ADDR    = 2'd0,
        CMD_HEADER  = 2'd1,
        CMD_PAYLOAD = 2'd2
    } cmd_t;

    typedef enum logic {
        KIND_SUM  = 1'b0,
        KIND_BYTE = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic        fin;
        logic [15:0] data;
    } item_t;

    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        logic [16:0] f;
        s = {1'b0, a} + {1'b0, b};
        f = {1'b0, s[15:0]} + {16'd0, s[16]};
        return f[15:0];
    endfunction

    function automatic logic [15:0] csum_fold(input logic [18:0] x);
        logic [16:0] f1;
        logic [16:0] f2;
        f1 = {1'b0, x[15:0]} + {14'd0, x[18:16]};
        f2 = {1'b0, f1[15:0]} + {16'd0, f1[16]};
        return f2[15:0];
    endfunction

endpackage

[hdl/icmpv6_checksum_generator_core.sv]
// Accepted words go into the queue; each packet's result is then registered onto m_tdata.
// Throughput: one word per cycle, set by the single end-around-carry add in the back end.
// A four-entry queue keeps input flowing while a result waits on m_tready, until it is full.
// Reset (aresetn low, synchronous) empties the queue, clears the accumulator,
// the held byte and the pending result.
module icmpv6_checksum_generator_core #(
    parameter int MAX_PAYLOAD = icmpcg_pkg::DEFAULT_MAX_PAYLOAD
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // tdata from bit 0: addr_chunk(64), next_header(8), msg_type(8), msg_code(8),
    // ident(16), sequence_req(16), payload_length(12), payload_byte(8), zero pad(4)
    input  logic [icmpcg_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                             s_tlast,
    // tuser from bit 0: command(2)
    input  logic [1:0]                       s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // tdata from bit 0: checksum_value(16)
    output logic [icmpcg_pkg::M_TDATA_W-1:0] m_tdata
);
    import icmpcg_pkg::*;

    logic  q_full;
    logic  q_push;
    logic  q_empty;
    logic  q_pop;
    item_t q_item;
    item_t q_head;

    icmpcg_front #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (q_item)
    );

    icmpcg_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (q_item),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head_item (q_head)
    );

    icmpcg_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

[hdl/icmpcg_front.sv]
// Front end: accepts input words, drops unused commands, reduces each address or
// header word to a folded partial sum and passes payload bytes on. Depends on icmpcg_pkg.
module icmpcg_front #(
    parameter int MAX_PAYLOAD = icmpcg_pkg::DEFAULT_MAX_PAYLOAD
) (
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // tdata from bit 0: addr_chunk(64), next_header(8), msg_type(8), msg_code(8),
    // ident(16), sequence_req(16), payload_length(12), payload_byte(8), zero pad(4)
    input  logic [icmpcg_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic                                s_tlast,
    // tuser from bit 0: command(2)
    input  logic [1:0]                          s_tuser,
    input  logic                                q_full,
    output logic                                q_push,
    output icmpcg_pkg::item_t                   q_item
);
    import icmpcg_pkg::*;

    logic [63:0] addr_chunk;
    logic [7:0]  next_header;
    logic [7:0]  msg_type;
    logic [7:0]  msg_code;
    logic [15:0] ident;
    logic [15:0] sequence_req;
    logic [11:0] payload_length;
    logic [7:0]  payload_byte;
    logic [15:0] plen_sat;
    logic [15:0] ulen;
    logic [18:0] chunk_sum;
    logic [18:0] header_sum;
    logic        valid_cmd;
    cmd_t        cmd;

    assign addr_chunk     = s_tdata[63:0];
    assign next_header    = s_tdata[71:64];
    assign msg_type       = s_tdata[79:72];
    assign msg_code       = s_tdata[87:80];
    assign ident          = s_tdata[103:88];
    assign sequence_req   = s_tdata[119:104];
    assign payload_length = s_tdata[131:120];
    assign payload_byte   = s_tdata[139:132];
    assign cmd            = cmd_t'(s_tuser);

    assign plen_sat = (32'(payload_length) > MAX_PAYLOAD) ? 16'(MAX_PAYLOAD)
                                                           : {4'd0, payload_length};
    assign ulen = plen_sat + 16'd8;

    assign chunk_sum = {3'd0, addr_chunk[63:48]} + {3'd0, addr_chunk[47:32]}
                     + {3'd0, addr_chunk[31:16]} + {3'd0, addr_chunk[15:0]};
    assign header_sum = {3'd0, ulen} + {11'd0, next_header} + {3'd0, msg_type, msg_code}
                      + {3'd0, ident} + {3'd0, sequence_req};

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && s_tready && valid_cmd;

    always_comb begin
        valid_cmd   = 1'b1;
        q_item.kind = KIND_SUM;
        q_item.fin  = 1'b0;
        q_item.data = 16'd0;
        unique case (cmd)
            CMD_ADDR: begin
                q_item.data = csum_fold(chunk_sum);
            end
            CMD_HEADER: begin
                q_item.data = csum_fold(header_sum);
                q_item.fin  = (plen_sat == 16'd0);
            end
            CMD_PAYLOAD: begin
                q_item.kind = KIND_BYTE;
                q_item.data = {8'd0, payload_byte};
                q_item.fin  = s_tlast;
            end
            default: begin
                valid_cmd = 1'b0;
            end
        endcase
    end

endmodule

[hdl/icmpcg_queue.sv]
// Short register queue that decouples the front end from the accumulator.
// Depends on icmpcg_pkg for the item type and depth constants.
module icmpcg_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  icmpcg_pkg::item_t push_item,
    output logic              full,
    input  logic              pop,
    output logic              empty,
    output icmpcg_pkg::item_t head_item
);
    import icmpcg_pkg::*;

    item_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign head_item = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count exceeds depth");

    assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push)
        else $error("push into a full queue");

    assert property (@(posedge aclk) disable iff (!aresetn)
        empty |-> !pop)
        else $error("pop from an empty queue");

endmodule

[hdl/icmpcg_back.sv]
// Back end: one's-complement accumulator, odd byte pairing and result register.
// Depends on icmpcg_pkg for the item type and the end-around-carry add.
module icmpcg_back (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             q_empty,
    input  icmpcg_pkg::item_t                q_head,
    output logic                             q_pop,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // tdata from bit 0: checksum_value(16)
    output logic [icmpcg_pkg::M_TDATA_W-1:0] m_tdata
);
    import icmpcg_pkg::*;

    logic [15:0] sum_reg;
    logic [15:0] sum_next;
    logic [7:0]  held_reg;
    logic [7:0]  held_next;
    logic        odd_reg;
    logic        odd_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [15:0] out_data_reg;
    logic [15:0] out_data_next;
    logic [15:0] word;
    logic [15:0] sum_new;

    assign q_pop = !q_empty && (!q_head.fin || !out_valid_reg || m_tready);

    always_comb begin
        sum_next  = sum_reg;
        held_next = held_reg;
        odd_next  = odd_reg;
        word      = 16'd0;
        case (q_head.kind)
            KIND_SUM: begin
                word      = q_head.data;
                held_next = 8'd0;
                odd_next  = 1'b0;
            end
            KIND_BYTE: begin
                if (odd_reg) begin
                    word      = {held_reg, q_head.data[7:0]};
                    held_next = 8'd0;
                    odd_next  = 1'b0;
                end else if (q_head.fin) begin
                    word = {q_head.data[7:0], 8'd0};
                end else begin
                    held_next = q_head.data[7:0];
                    odd_next  = 1'b1;
                end
            end
            default: begin
                word = 16'd0;
            end
        endcase
        sum_new  = oc_add(sum_reg, word);
        sum_next = sum_new;
        if (q_head.fin) begin
            sum_next  = 16'd0;
            held_next = 8'd0;
            odd_next  = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        if (q_pop && q_head.fin) begin
            out_valid_next = 1'b1;
            out_data_next  = ~sum_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg       <= 16'd0;
            held_reg      <= 8'd0;
            odd_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (q_pop) begin
                sum_reg  <= sum_next;
                held_reg <= held_next;
                odd_reg  <= odd_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop && q_head.fin |=> m_tvalid)
        else $error("finished packet did not raise a result");

    assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop && q_head.fin |=> sum_reg == 16'd0 && !odd_reg && held_reg == 8'd0)
        else $error("accumulator not cleared after a result");

    assert property (@(posedge aclk) disable iff (!aresetn)
        !odd_reg |-> held_reg == 8'd0)
        else $error("held byte present without odd phase");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("pending result dropped");

endmodule

[tb/tb_top.sv]
// Self-checking testbench for icmpv6_checksum_generator_core: streams ICMPv6 packets as words,
// predicts every checksum in the bench itself and compares each result word on the m_ side.
// Depends on hdl/icmpcg_pkg.sv and hdl/icmpv6_checksum_generator_core.sv.
module tb_top;
    import icmpcg_pkg::*;

    localparam int MAX_LEN = DEFAULT_MAX_PAYLOAD;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int HOLD_CYCLES = 400;
    localparam int TIMEOUT_CYCLES = 400000;

    typedef enum {
        PH_DIRECTED,
        PH_FREE,
        PH_SEND_IDLE,
        PH_RECV_STALL,
        PH_BOTH,
        PH_PRESSURE
    } phase_t;

    typedef struct {
        logic [1:0]  cmd;
        logic [63:0] chunk;
        logic [7:0]  nxt_hdr;
        logic [7:0]  msg_type;
        logic [7:0]  msg_code;
        logic [15:0] ident;
        logic [15:0] seq_num;
        logic [11:0] plen;
        logic [7:0]  pbyte;
        logic        last;
    } word_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 s_tlast = 1'b0;
    logic [1:0]           s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    word_t       tx_words[$];
    logic [15:0] checksums_due[$];
    word_t       cur_word;
    logic [15:0] due_sum;
    phase_t      phase = PH_DIRECTED;
    int          hold_left = 0;
    logic        hold_used = 1'b0;
    int          errors = 0;

    logic [15:0] acc_sum = '0;
    logic [7:0]  held_byte = '0;
    logic        byte_waiting = 1'b0;

    icmpv6_checksum_generator_core #(
        .MAX_PAYLOAD(MAX_LEN)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tlast(s_tlast),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    always #10 aclk = ~aclk;

    function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
        int unsigned s;
        s = 32'(a) + 32'(b);
        if (s > 32'hffff) s = s - 32'hffff;
        return s[15:0];
    endfunction

    function automatic void checksum_track(input word_t w);
        int unsigned len;
        int unsigned ulen;
        case (w.cmd)
            CMD_ADDR: begin
                for (int k = 0; k < 4; k++) acc_sum = ones_add(acc_sum, w.chunk[63 - 16 * k -: 16]);
                held_byte = '0;
                byte_waiting = 1'b0;
            end
            CMD_HEADER: begin
                len = (w.plen > MAX_LEN) ? MAX_LEN : w.plen;
                ulen = 32'd8 + len;
                acc_sum = ones_add(acc_sum, ulen[31:16]);
                acc_sum = ones_add(acc_sum, ulen[15:0]);
                acc_sum = ones_add(acc_sum, {8'h00, w.nxt_hdr});
                acc_sum = ones_add(acc_sum, {w.msg_type, w.msg_code});
                acc_sum = ones_add(acc_sum, w.ident);
                acc_sum = ones_add(acc_sum, w.seq_num);
                held_byte = '0;
                byte_waiting = 1'b0;
                if (len == 0) begin
                    checksums_due.push_back(~acc_sum);
                    acc_sum = '0;
                end
            end
            CMD_PAYLOAD: begin
                if (byte_waiting) begin
                    acc_sum = ones_add(acc_sum, {held_byte, w.pbyte});
                    held_byte = '0;
                    byte_waiting = 1'b0;
                end else if (w.last) begin
                    acc_sum = ones_add(acc_sum, {w.pbyte, 8'h00});
                end else begin
                    held_byte = w.pbyte;
                    byte_waiting = 1'b1;
                end
                if (w.last) begin
                    checksums_due.push_back(~acc_sum);
                    acc_sum = '0;
                    held_byte = '0;
                    byte_waiting = 1'b0;
                end
            end
            default: begin
            end
        endcase
    endfunction

    function automatic logic [S_TDATA_W-1:0] pack_word(input word_t w);
        return {4'b0, w.pbyte, w.plen, w.seq_num, w.ident, w.msg_code, w.msg_type,
                w.nxt_hdr, w.chunk};
    endfunction

    function automatic word_t rand_word(input logic [1:0] cmd);
        word_t w;
        w.cmd      = cmd;
        w.chunk    = {$urandom, $urandom};
        w.nxt_hdr  = 8'($urandom_range(255));
        w.msg_type = 8'($urandom_range(255));
        w.msg_code = 8'($urandom_range(255));
        w.ident    = 16'($urandom_range(65535));
        w.seq_num  = 16'($urandom_range(65535));
        w.plen     = 12'($urandom_range(4095));
        w.pbyte    = 8'($urandom_range(255));
        w.last     = 1'($urandom_range(1));
        return w;
    endfunction

    function automatic int send_idle_pct();
        if (phase == PH_SEND_IDLE) return 86;
        if (phase == PH_BOTH) return 18;
        return 0;
    endfunction

    function automatic int recv_stall_pct();
        if (phase == PH_RECV_STALL) return 86;
        if (phase == PH_BOTH) return 18;
        return 0;
    endfunction

    task automatic push_packet(input logic [11:0] plen, input int nbytes, input logic with_last);
        word_t w;
        for (int k = 0; k < 4; k++) tx_words.push_back(rand_word(CMD_ADDR));
        w = rand_word(CMD_HEADER);
        w.plen = plen;
        tx_words.push_back(w);
        for (int i = 0; i < nbytes; i++) begin
            w = rand_word(CMD_PAYLOAD);
            w.last = with_last && (i == nbytes - 1);
            tx_words.push_back(w);
        end
    endtask

    task automatic random_traffic(input int n_words);
        int sent;
        int r;
        int nb;
        logic [11:0] plen;
        word_t w;
        sent = 0;
        while (sent < n_words) begin
            r = $urandom_range(99);
            plen = 12'($urandom_range(1, 24));
            if (r < 78) begin
                r = $urandom_range(99);
                if (r < 10) begin
                    plen = '0;
                    nb = 0;
                end else if (r < 90) begin
                    nb = int'(plen);
                end else if (r < 96) begin
                    plen = 12'($urandom_range(25, 64));
                    nb = int'(plen);
                end else begin
                    plen = 12'($urandom_range(MAX_LEN - 8, 4095));
                    nb = $urandom_range(1, 8);
                end
                push_packet(plen, nb, 1'b1);
                sent += 5 + nb;
            end else if (r < 84) begin
                tx_words.push_back(rand_word(CMD_UNUSED));
            end else if (r < 89) begin
                nb = $urandom_range(1, 6);
                for (int i = 0; i < nb; i++) begin
                    w = rand_word(CMD_PAYLOAD);
                    w.last = (i == nb - 1);
                    tx_words.push_back(w);
                end
                sent += nb;
            end else if (r < 94) begin
                nb = $urandom_range(0, plen);
                push_packet(plen, nb, 1'b0);
                sent += 5 + nb;
            end else begin
                nb = $urandom_range(1, plen + 4);
                push_packet(plen, nb, 1'b1);
                sent += 5 + nb;
            end
        end
    endtask

    task automatic drain();
        while (tx_words.size() != 0 || s_tvalid || checksums_due.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        @(negedge aclk);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) checksum_track(cur_word);
            if (!s_tvalid || s_tready) begin
                if (tx_words.size() != 0 && $urandom_range(99) >= send_idle_pct()) begin
                    cur_word = tx_words.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= pack_word(cur_word);
                    s_tlast  <= cur_word.last;
                    s_tuser  <= cur_word.cmd;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
            hold_used <= 1'b0;
        end else if (phase == PH_PRESSURE && !hold_used) begin
            hold_left <= HOLD_CYCLES;
            hold_used <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (checksums_due.size() == 0) begin
                    $display("%0t: unexpected checksum word, expected none, actual %h",
                             $time, m_tdata);
                    errors++;
                end else begin
                    due_sum = checksums_due.pop_front();
                    if (m_tdata !== due_sum) begin
                        $display("%0t: checksum_value mismatch, expected %h, actual %h",
                                 $time, due_sum, m_tdata);
                        errors++;
                    end
                end
            end
            m_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct());
        end
    end

    initial begin
        word_t w;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Extreme addresses and header fields with an empty payload.
        w = rand_word(CMD_ADDR);
        w.chunk = '0;
        tx_words.push_back(w);
        tx_words.push_back(w);
        w.chunk = '1;
        tx_words.push_back(w);
        tx_words.push_back(w);
        w = rand_word(CMD_HEADER);
        w.nxt_hdr = '1;
        w.msg_type = '1;
        w.msg_code = '1;
        w.ident = '1;
        w.seq_num = '1;
        w.plen = '0;
        tx_words.push_back(w);

        // Largest legal length with one odd trailing byte.
        w = rand_word(CMD_ADDR);
        w.chunk = '1;
        for (int k = 0; k < 4; k++) tx_words.push_back(w);
        w = rand_word(CMD_HEADER);
        w.nxt_hdr = '0;
        w.msg_type = '0;
        w.msg_code = '0;
        w.ident = '0;
        w.seq_num = '0;
        w.plen = 12'(MAX_LEN);
        tx_words.push_back(w);
        w = rand_word(CMD_PAYLOAD);
        w.pbyte = '1;
        w.last = 1'b1;
        tx_words.push_back(w);

        // Oversized length saturates; two payload bytes.
        push_packet(12'hfff, 2, 1'b1);

        // Unused command, then payload bytes with no header open.
        tx_words.push_back(rand_word(CMD_UNUSED));
        w = rand_word(CMD_PAYLOAD);
        w.pbyte = '0;
        w.last = 1'b0;
        tx_words.push_back(w);
        w.last = 1'b1;
        tx_words.push_back(w);

        // A held odd byte is dropped when an address word arrives.
        w = rand_word(CMD_HEADER);
        w.plen = 12'd3;
        tx_words.push_back(w);
        w = rand_word(CMD_PAYLOAD);
        w.last = 1'b0;
        tx_words.push_back(w);
        tx_words.push_back(rand_word(CMD_ADDR));
        w = rand_word(CMD_PAYLOAD);
        w.last = 1'b1;
        tx_words.push_back(w);
        drain();

        phase = PH_FREE;
        random_traffic(200);
        drain();

        phase = PH_SEND_IDLE;
        random_traffic(140);
        drain();

        phase = PH_RECV_STALL;
        random_traffic(140);
        drain();

        phase = PH_BOTH;
        random_traffic(140);
        drain();

        // Header-only packets while the receiver holds off, so the block backs up.
        phase = PH_PRESSURE;
        for (int i = 0; i < 40; i++) push_packet(12'd0, 0, 1'b1);
        random_traffic(60);
        drain();

        repeat (20) @(posedge aclk);
        if (errors == 0) begin
            $display("** icmpv6_checksum_generator_core: PASSED **");
        end else begin
            $display("** icmpv6_checksum_generator_core: FAILED **");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_CYCLES * 20);
        $display("** icmpv6_checksum_generator_core: FAILED **");
        $finish;
    end

endmodule

[sim.f]
hdl/icmpcg_pkg.sv
hdl/icmpcg_front.sv
hdl/icmpcg_queue.sv
hdl/icmpcg_back.sv
hdl/icmpv6_checksum_generator_core.sv
tb/tb_top.sv
